// ===== sv/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, codes and helpers of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int DEF_STACK_DEPTH = 16;

    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_OVER    = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_BADCHAR = 3'd4;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
        logic       last;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    function automatic logic [31:0] sat32(input logic signed [48:0] v);
        if (v > 49'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -49'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== sv/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression in signed Q16.16, one character per request.
//
//   channel  dir  tdata            tuser        tlast
//   s_axis   in   [7:0] expr_char  -            last_char
//   m_axis   out  [31:0] value     [2:0] status -
//
// Push, bad or ignored character: S_IDLE only. + and -: S_IDLE, S_READ.
// *: S_IDLE, S_READ, S_MUL. /: S_IDLE, S_READ, S_DIV (48-step serial divider).
// A last character adds S_EMIT to load the output register.
// A two-entry queue decouples input from execution; the output register
// holds a result until taken and the back end waits on it only to emit.
// Synchronous active-low reset; the stack RAM needs no clearing.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] expr_char
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [2:0]  m_axis_tuser    // [2:0] status
);
    import pfe_pkg::*;

    logic  push;
    logic  full;
    logic  q_valid;
    logic  pop;
    t_item f_item;
    t_item q_item;

    pfe_front u_front (
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_char (s_axis_tdata),
        .i_last (s_axis_tlast),
        .o_push (push),
        .o_item (f_item),
        .i_full (full)
    );

    pfe_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (f_item),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_item (q_item)
    );

    pfe_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_value (m_axis_tdata),
        .o_m_status(m_axis_tuser)
    );

endmodule

// ===== sv/pfe_ram.sv =====
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pfe_front.sv =====
// ----------------------------------------------------------------------------
// pfe_front
// Accepts expression characters and decodes them into queue items.
// ----------------------------------------------------------------------------
module pfe_front (
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_char,
    input  logic           i_last,
    output logic           o_push,
    output pfe_pkg::t_item o_item,
    input  logic           i_full
);
    import pfe_pkg::*;

    logic [3:0] digit_off;

    assign o_ready   = !i_full;
    assign o_push    = i_valid && !i_full;
    assign digit_off = 4'(i_char - CH_0);

    always_comb begin
        o_item.digit = digit_off;
        o_item.last  = i_last;
        unique case (i_char) inside
            [CH_0:CH_9]: o_item.op = OP_PUSH;
            CH_ADD:      o_item.op = OP_ADD;
            CH_SUB:      o_item.op = OP_SUB;
            CH_MUL:      o_item.op = OP_MUL;
            CH_DIV:      o_item.op = OP_DIV;
            default:     o_item.op = OP_BAD;
        endcase
    end

endmodule

// ===== sv/pfe_fifo.sv =====
// ----------------------------------------------------------------------------
// pfe_fifo
// Two-entry queue of decoded items between front and back.
// ----------------------------------------------------------------------------
module pfe_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pfe_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pfe_pkg::t_item o_item
);
    import pfe_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ===== sv/pfe_div.sv =====
// ----------------------------------------------------------------------------
// pfe_div
// Bit-serial restoring divider for Q16.16 division, saturated result.
// ----------------------------------------------------------------------------
module pfe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    input  logic        i_neg,
    output logic        o_done,
    output logic [31:0] o_result
);
    import pfe_pkg::*;

    localparam int QW   = 48;
    localparam int CNTW = $clog2(QW + 1);

    logic [QW-1:0]        r_q;
    logic [31:0]          r_rem;
    logic [31:0]          r_div;
    logic                 r_neg;
    logic [CNTW-1:0]      r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [32:0]          trial;
    logic                 take;
    logic signed [QW:0]   q_ext;
    logic signed [QW:0]   q_signed;

    assign trial    = {r_rem, r_q[QW-1]};
    assign take     = (trial >= {1'b0, r_div});
    assign q_ext    = {1'b0, r_q};
    assign q_signed = r_neg ? -q_ext : q_ext;
    assign o_result = sat32(q_signed);
    assign o_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {i_dividend, 16'd0};
            r_rem <= 32'd0;
            r_div <= i_divisor;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_q   <= {r_q[QW-2:0], take};
            r_rem <= take ? 32'(trial - {1'b0, r_div}) : trial[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/pfe_back.sv =====
// ----------------------------------------------------------------------------
// pfe_back
// Executes queued items on the operand stack and produces the result.
// Top of stack lives in a register, the entries below it in a RAM.
// ----------------------------------------------------------------------------
module pfe_back #(
    parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pfe_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output logic [31:0]    o_m_value,
    output logic [2:0]     o_m_status
);
    import pfe_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [2:0]         r_err, n_err;
    logic [31:0]        r_tos, n_tos;
    t_op                r_op, n_op;
    logic               r_last, n_last;
    logic signed [63:0] r_prod, n_prod;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_out_value, n_out_value;
    logic [2:0]         r_out_status, n_out_status;

    logic               ram_we;
    logic [31:0]        ram_rdata;
    logic [CW-1:0]      cnt_m1;
    logic [AW-1:0]      cnt_m2;
    logic               out_free;
    t_state             done_state;
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic signed [32:0] sum;
    logic signed [32:0] dif;
    logic signed [47:0] mq;
    logic [31:0]        a_mag;
    logic [31:0]        b_mag;
    logic               div_start;
    logic               div_done;
    logic [31:0]        div_result;

    assign cnt_m1     = r_count - CW'(1);
    assign cnt_m2     = AW'(r_count - CW'(2));
    assign out_free   = !r_out_valid || i_m_ready;
    assign done_state = r_last ? S_EMIT : S_IDLE;
    assign sa         = ram_rdata;
    assign sb         = r_tos;
    assign sum        = {sa[31], sa} + {sb[31], sb};
    assign dif        = {sa[31], sa} - {sb[31], sb};
    assign mq         = r_prod[63:16] + {47'd0, (r_prod[63] && (r_prod[15:0] != 16'd0))};
    assign a_mag      = sa[31] ? -ram_rdata : ram_rdata;
    assign b_mag      = sb[31] ? -r_tos : r_tos;

    pfe_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(cnt_m1[AW-1:0]),
        .i_wdata(r_tos),
        .i_raddr(cnt_m2),
        .o_rdata(ram_rdata)
    );

    pfe_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(a_mag),
        .i_divisor (b_mag),
        .i_neg     (sa[31] ^ sb[31]),
        .o_done    (div_done),
        .o_result  (div_result)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_err        = r_err;
        n_tos        = r_tos;
        n_op         = r_op;
        n_last       = r_last;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid && !i_m_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        o_pop        = 1'b0;
        ram_we       = 1'b0;
        div_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_op    = i_item.op;
                    n_last  = i_item.last;
                    n_state = i_item.last ? S_EMIT : S_IDLE;
                    if (r_err == ST_OK) begin
                        unique case (i_item.op)
                            OP_PUSH: begin
                                if (r_count == CW'(STACK_DEPTH)) begin
                                    n_err = ST_OVER;
                                end else begin
                                    ram_we  = (r_count != '0);
                                    n_tos   = {12'd0, i_item.digit, 16'd0};
                                    n_count = r_count + CW'(1);
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                                if (r_count < CW'(2)) begin
                                    n_err = ST_UNDER;
                                end else if (i_item.op == OP_DIV && r_tos == '0) begin
                                    n_err = ST_DIVZERO;
                                end else begin
                                    n_state = S_READ;
                                end
                            end
                            default: n_err = ST_BADCHAR;
                        endcase
                    end
                end
            end
            S_READ: begin
                case (r_op)
                    OP_ADD: begin
                        n_tos   = sat32(49'(sum));
                        n_count = cnt_m1;
                        n_state = done_state;
                    end
                    OP_SUB: begin
                        n_tos   = sat32(49'(dif));
                        n_count = cnt_m1;
                        n_state = done_state;
                    end
                    OP_MUL: begin
                        n_prod  = sa * sb;
                        n_state = S_MUL;
                    end
                    default: begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                endcase
            end
            S_MUL: begin
                n_tos   = sat32(49'(mq));
                n_count = cnt_m1;
                n_state = done_state;
            end
            S_DIV: begin
                if (div_done) begin
                    n_tos   = div_result;
                    n_count = cnt_m1;
                    n_state = done_state;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_err != ST_OK) begin
                        n_out_status = r_err;
                        n_out_value  = '0;
                    end else if (r_count == '0) begin
                        n_out_status = ST_UNDER;
                        n_out_value  = '0;
                    end else begin
                        n_out_status = ST_OK;
                        n_out_value  = r_tos;
                    end
                    n_count = '0;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos        <= n_tos;
        r_op         <= n_op;
        r_last       <= n_last;
        r_prod       <= n_prod;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_m_valid  = r_out_valid;
    assign o_m_value  = r_out_value;
    assign o_m_status = r_out_status;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (r_count == '0 && r_err == ST_OK && r_out_valid))
        else $error("emit did not clear stack and error");

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_value == '0))
        else $error("nonzero value with error status");

    a_op_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_count >= CW'(2) && r_err == ST_OK))
        else $error("operator executed without two operands");
`endif

endmodule
